/* hw/rtl/lpb_pkg.sv */
// Shared types, command codes and default sizes for the LRU page buffer pool.
package lpb_pkg;

    localparam int DEF_NUM_SLOTS = 16;
    localparam int DEF_FILE_BITS = 10;
    localparam int DEF_PAGE_BITS = 24;
    localparam int DEF_PIN_BITS  = 8;

    localparam int CMD_BITS = 3;

    localparam logic [CMD_BITS-1:0] CMD_GET   = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_ALLOC = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_DIRTY = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_UNPIN = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_FORCE = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_FLUSH = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_CLAIM,
        ST_VSEARCH,
        ST_UNLINK,
        ST_LINK,
        ST_INVAL,
        ST_FILL,
        ST_EMIT,
        ST_FWALK
    } t_state;

endpackage

/* hw/rtl/lpb_out_reg.sv */
// Output register that holds one result transfer until the consumer takes it.
module lpb_out_reg #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  logic [W-1:0] i_data,
    input  logic         i_ready,
    output logic         o_valid,
    output logic [W-1:0] o_data
);

    logic         r_valid;
    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* hw/rtl/lru_page_buffer_pool.sv */
// Top level of the LRU page buffer pool: command sequencer, slot state and list links.
// A lookup scans the slots in order from slot 0; a get that misses and an allocate claim a free
// slot, or else search the list from its tail for an unpinned victim. A flush walks the list from
// its head and stalls on the result port. Throughput: one command at a time, accepted the cycle
// after the final result loads. Reset: synchronous, active low; the tag stores, the command
// context and the result under construction are not reset, r_claim apart.
module lru_page_buffer_pool #(
    parameter int NUM_SLOTS = lpb_pkg::DEF_NUM_SLOTS,
    parameter int FILE_BITS = lpb_pkg::DEF_FILE_BITS,
    parameter int PAGE_BITS = lpb_pkg::DEF_PAGE_BITS,
    parameter int PIN_BITS  = lpb_pkg::DEF_PIN_BITS,
    localparam int SW = $clog2(NUM_SLOTS),
    localparam int LW = $clog2(NUM_SLOTS + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [lpb_pkg::CMD_BITS-1:0] i_command,
    input  logic [FILE_BITS-1:0]         i_file_id,
    input  logic [PAGE_BITS-1:0]         i_page_num,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_status,
    output logic                         o_hit,
    output logic [SW-1:0]                o_slot,
    output logic                         o_writeback_valid,
    output logic [FILE_BITS-1:0]         o_writeback_file,
    output logic [PAGE_BITS-1:0]         o_writeback_page,
    output logic [SW-1:0]                o_writeback_slot,
    output logic                         o_fill_valid,
    output logic                         o_last
);

    // The list code one past the last slot stands for "no slot".
    localparam logic [LW-1:0]       NIL     = LW'(NUM_SLOTS);
    localparam logic [SW-1:0]       IDX_END = SW'(NUM_SLOTS - 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
    localparam int                  OW      = 5 + 2 * SW + FILE_BITS + PAGE_BITS;

    lpb_pkg::t_state r_state, n_state;

    // Slot state.
    logic [FILE_BITS-1:0] r_tfile [NUM_SLOTS];
    logic [PAGE_BITS-1:0] r_tpage [NUM_SLOTS];
    logic                 r_valid [NUM_SLOTS];
    logic [PIN_BITS-1:0]  r_pin   [NUM_SLOTS];
    logic                 r_dirty [NUM_SLOTS];
    logic [LW-1:0]        r_prev  [NUM_SLOTS];
    logic [LW-1:0]        r_next  [NUM_SLOTS];
    logic [LW-1:0]        r_head, r_tail, r_free;

    // Command context.
    logic [lpb_pkg::CMD_BITS-1:0] r_cmd;
    logic [FILE_BITS-1:0]         r_f;
    logic [PAGE_BITS-1:0]         r_p;
    logic [SW-1:0]                r_s;
    logic [SW-1:0]                r_idx;
    logic [LW-1:0]                r_ptr;
    logic [LW-1:0]                r_steps;
    logic                         r_claim;

    // Result under construction.
    logic                 r_status, r_hit, r_wbv, r_fill;
    logic [SW-1:0]        r_rslot, r_wbs;
    logic [FILE_BITS-1:0] r_wbf;
    logic [PAGE_BITS-1:0] r_wbp;

    // The single shared file-and-page tag comparator looks at the slot chosen by the scan index.
    logic w_match;
    assign w_match = r_valid[r_idx] && (r_tfile[r_idx] == r_f) && (r_tpage[r_idx] == r_p);

    // The list walker (victim search and flush) follows r_ptr.
    logic [SW-1:0] w_ps;
    logic          w_pnil;
    logic          w_wdone;
    logic          w_fmatch;
    assign w_ps     = r_ptr[SW-1:0];
    assign w_pnil   = (r_ptr >= NIL);
    assign w_wdone  = w_pnil || (r_steps == NIL);
    assign w_fmatch = !w_pnil && (r_tfile[w_ps] == r_f);

    // Unlink target: the walker's slot during a flush, otherwise the command's slot.
    logic [SW-1:0] w_u;
    logic [LW-1:0] w_un, w_up;
    assign w_u  = (r_state == lpb_pkg::ST_FWALK) ? w_ps : r_s;
    assign w_un = r_next[w_u];
    assign w_up = r_prev[w_u];

    logic [PIN_BITS-1:0] w_pin_dec;
    assign w_pin_dec = (r_pin[r_s] != '0) ? r_pin[r_s] - 1'b1 : '0;

    logic w_out_free;
    logic w_fstall;
    logic w_fstep;
    assign w_out_free = !o_out_valid || i_out_ready;
    assign w_fstall   = !w_wdone && w_fmatch && r_dirty[w_ps] && !w_out_free;
    assign w_fstep    = (r_state == lpb_pkg::ST_FWALK) && !w_wdone && !w_fstall;

    logic w_accept;
    assign w_accept = i_in_valid && o_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            lpb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    case (i_command)
                        lpb_pkg::CMD_GET, lpb_pkg::CMD_DIRTY,
                        lpb_pkg::CMD_UNPIN, lpb_pkg::CMD_FORCE: n_state = lpb_pkg::ST_LOOKUP;
                        lpb_pkg::CMD_ALLOC:                     n_state = lpb_pkg::ST_CLAIM;
                        lpb_pkg::CMD_FLUSH:                     n_state = lpb_pkg::ST_FWALK;
                        default:                                n_state = lpb_pkg::ST_EMIT;
                    endcase
                end
            end
            lpb_pkg::ST_LOOKUP: begin
                if (w_match) begin
                    n_state = (r_cmd == lpb_pkg::CMD_GET) ? lpb_pkg::ST_UNLINK
                                                          : lpb_pkg::ST_UPDATE;
                end else if (r_idx == IDX_END) begin
                    n_state = (r_cmd == lpb_pkg::CMD_GET) ? lpb_pkg::ST_CLAIM
                                                          : lpb_pkg::ST_EMIT;
                end
            end
            lpb_pkg::ST_UPDATE: begin
                case (r_cmd)
                    lpb_pkg::CMD_DIRTY: n_state = lpb_pkg::ST_UNLINK;
                    lpb_pkg::CMD_UNPIN: n_state = (w_pin_dec == '0) ? lpb_pkg::ST_UNLINK
                                                                    : lpb_pkg::ST_EMIT;
                    default:            n_state = lpb_pkg::ST_EMIT;
                endcase
            end
            lpb_pkg::ST_CLAIM: begin
                n_state = (r_free < NIL) ? lpb_pkg::ST_LINK : lpb_pkg::ST_VSEARCH;
            end
            lpb_pkg::ST_VSEARCH: begin
                if (w_pnil || (r_steps == NIL)) begin
                    n_state = lpb_pkg::ST_EMIT;
                end else if (r_pin[w_ps] == '0) begin
                    n_state = lpb_pkg::ST_UNLINK;
                end
            end
            lpb_pkg::ST_UNLINK: n_state = lpb_pkg::ST_LINK;
            lpb_pkg::ST_LINK: begin
                if (!r_claim) begin
                    n_state = lpb_pkg::ST_EMIT;
                end else if (r_cmd == lpb_pkg::CMD_ALLOC) begin
                    n_state = lpb_pkg::ST_INVAL;
                end else begin
                    n_state = lpb_pkg::ST_FILL;
                end
            end
            lpb_pkg::ST_INVAL: begin
                if (r_idx == IDX_END) begin
                    n_state = lpb_pkg::ST_FILL;
                end
            end
            lpb_pkg::ST_FILL: n_state = lpb_pkg::ST_EMIT;
            lpb_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_state = lpb_pkg::ST_IDLE;
                end
            end
            lpb_pkg::ST_FWALK: begin
                if (w_wdone && w_out_free) begin
                    n_state = lpb_pkg::ST_IDLE;
                end
            end
            default: n_state = lpb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lpb_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Outputs of the sequencer: input ready and the result transfer to load.
    logic          w_load;
    logic [OW-1:0] w_odata;
    logic [OW-1:0] w_oreg;

    always_comb begin
        o_in_ready = (r_state == lpb_pkg::ST_IDLE);
        w_load     = 1'b0;
        w_odata    = '0;
        case (r_state)
            lpb_pkg::ST_EMIT: begin
                w_load  = w_out_free;
                w_odata = {r_status, r_hit, r_rslot, r_wbv, r_wbf, r_wbp, r_wbs,
                           r_fill, 1'b1};
            end
            lpb_pkg::ST_FWALK: begin
                if (w_wdone) begin
                    // The closing transfer of a flush carries only the last flag.
                    w_load  = w_out_free;
                    w_odata = {{(OW - 1){1'b0}}, 1'b1};
                end else begin
                    // A dirty page of the file goes out in a transfer of its own.
                    w_load  = w_fmatch && r_dirty[w_ps] && w_out_free;
                    w_odata = {1'b0, 1'b0, {SW{1'b0}}, 1'b1, r_tfile[w_ps], r_tpage[w_ps],
                               w_ps, 1'b0, 1'b0};
                end
            end
            default: begin
                w_load  = 1'b0;
                w_odata = '0;
            end
        endcase
    end

    lpb_out_reg #(
        .W(OW)
    ) u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_data  (w_odata),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (w_oreg)
    );

    assign {o_status, o_hit, o_slot, o_writeback_valid, o_writeback_file, o_writeback_page,
            o_writeback_slot, o_fill_valid, o_last} = w_oreg;

    // Slot state and list maintenance. Where this block assigns the same entry twice, the later
    // assignment wins, which is how a flushed slot's next link ends up pointing at the free list.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_valid[i] <= 1'b0;
                r_pin[i]   <= '0;
                r_dirty[i] <= 1'b0;
                r_prev[i]  <= (i == 0) ? NIL : LW'(i - 1);
                r_next[i]  <= LW'(i + 1);
            end
            r_head <= NIL;
            r_tail <= NIL;
            r_free <= '0;
        end else begin
            case (r_state)
                lpb_pkg::ST_LOOKUP: begin
                    if (w_match && (r_cmd == lpb_pkg::CMD_GET) && (r_pin[r_idx] != PIN_MAX)) begin
                        r_pin[r_idx] <= r_pin[r_idx] + 1'b1;
                    end
                end
                lpb_pkg::ST_UPDATE: begin
                    case (r_cmd)
                        lpb_pkg::CMD_DIRTY: r_dirty[r_s] <= 1'b1;
                        lpb_pkg::CMD_UNPIN: r_pin[r_s]   <= w_pin_dec;
                        default:            r_dirty[r_s] <= 1'b0;
                    endcase
                end
                lpb_pkg::ST_CLAIM: begin
                    if (r_free < NIL) begin
                        r_free <= r_next[r_free[SW-1:0]];
                    end
                end
                lpb_pkg::ST_VSEARCH: begin
                    if (!w_pnil && (r_steps != NIL) && (r_pin[w_ps] == '0)) begin
                        r_dirty[w_ps] <= 1'b0;
                        r_valid[w_ps] <= 1'b0;
                    end
                end
                lpb_pkg::ST_UNLINK, lpb_pkg::ST_FWALK: begin
                    if ((r_state == lpb_pkg::ST_UNLINK) || (w_fstep && w_fmatch)) begin
                        if (r_head == LW'(w_u)) begin
                            r_head <= w_un;
                        end
                        if (r_tail == LW'(w_u)) begin
                            r_tail <= w_up;
                        end
                        if (w_un < NIL) begin
                            r_prev[w_un[SW-1:0]] <= w_up;
                        end
                        if (w_up < NIL) begin
                            r_next[w_up[SW-1:0]] <= w_un;
                        end
                        r_prev[w_u] <= NIL;
                        r_next[w_u] <= NIL;
                        if (r_state == lpb_pkg::ST_FWALK) begin
                            r_dirty[w_u] <= 1'b0;
                            r_valid[w_u] <= 1'b0;
                            r_next[w_u]  <= r_free;
                            r_free       <= r_ptr;
                        end
                    end
                end
                lpb_pkg::ST_LINK: begin
                    r_next[r_s] <= r_head;
                    r_prev[r_s] <= NIL;
                    if (r_head < NIL) begin
                        r_prev[r_head[SW-1:0]] <= LW'(r_s);
                    end
                    r_head <= LW'(r_s);
                    if (r_tail >= NIL) begin
                        r_tail <= LW'(r_s);
                    end
                end
                lpb_pkg::ST_INVAL: begin
                    if ((r_idx != r_s) && w_match) begin
                        r_valid[r_idx] <= 1'b0;
                    end
                end
                lpb_pkg::ST_FILL: begin
                    r_valid[r_s] <= 1'b1;
                    r_dirty[r_s] <= 1'b0;
                    r_pin[r_s]   <= PIN_BITS'(1);
                end
                default: begin
                end
            endcase
        end
    end

    // Tags have no reset: they are read only for slots that have been filled.
    always_ff @(posedge i_clk) begin
        if (r_state == lpb_pkg::ST_FILL) begin
            r_tfile[r_s] <= r_f;
            r_tpage[r_s] <= r_p;
        end
    end

    // Command context and the result being assembled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_claim <= 1'b0;
        end else begin
            case (r_state)
                lpb_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_cmd    <= i_command;
                        r_f      <= i_file_id;
                        r_p      <= i_page_num;
                        r_idx    <= '0;
                        r_steps  <= '0;
                        r_ptr    <= r_head;
                        r_claim  <= 1'b0;
                        r_status <= 1'b0;
                        r_hit    <= 1'b0;
                        r_rslot  <= '0;
                        r_wbv    <= 1'b0;
                        r_wbf    <= '0;
                        r_wbp    <= '0;
                        r_wbs    <= '0;
                        r_fill   <= 1'b0;
                    end
                end
                lpb_pkg::ST_LOOKUP: begin
                    if (w_match) begin
                        r_s     <= r_idx;
                        r_hit   <= 1'b1;
                        r_rslot <= r_idx;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                lpb_pkg::ST_UPDATE: begin
                    if ((r_cmd == lpb_pkg::CMD_FORCE) && r_dirty[r_s]) begin
                        r_wbv <= 1'b1;
                        r_wbf <= r_tfile[r_s];
                        r_wbp <= r_tpage[r_s];
                        r_wbs <= r_s;
                    end
                end
                lpb_pkg::ST_CLAIM: begin
                    if (r_free < NIL) begin
                        r_s     <= r_free[SW-1:0];
                        r_claim <= 1'b1;
                    end else begin
                        r_ptr   <= r_tail;
                        r_steps <= '0;
                    end
                end
                lpb_pkg::ST_VSEARCH: begin
                    if (w_pnil || (r_steps == NIL)) begin
                        r_status <= 1'b1;
                    end else if (r_pin[w_ps] == '0) begin
                        r_s     <= w_ps;
                        r_claim <= 1'b1;
                        if (r_dirty[w_ps]) begin
                            r_wbv <= 1'b1;
                            r_wbf <= r_tfile[w_ps];
                            r_wbp <= r_tpage[w_ps];
                            r_wbs <= w_ps;
                        end
                    end else begin
                        r_ptr   <= r_prev[w_ps];
                        r_steps <= r_steps + 1'b1;
                    end
                end
                lpb_pkg::ST_LINK: begin
                    r_idx <= '0;
                end
                lpb_pkg::ST_INVAL: begin
                    r_idx <= r_idx + 1'b1;
                end
                lpb_pkg::ST_FILL: begin
                    r_rslot <= r_s;
                    r_fill  <= (r_cmd == lpb_pkg::CMD_GET);
                end
                lpb_pkg::ST_FWALK: begin
                    if (w_fstep) begin
                        r_ptr   <= r_next[w_ps];
                        r_steps <= r_steps + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // The LRU list is either empty at both ends or at neither.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head >= NIL) == (r_tail >= NIL))
        else $error("LRU head and tail disagree on an empty list");

    // Between commands the head of the list has no predecessor.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lpb_pkg::ST_IDLE && r_head < NIL) |-> (r_prev[r_head[SW-1:0]] == NIL))
        else $error("LRU head has a predecessor");

    // A resident page never asks for a fill.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_fill_valid))
        else $error("hit transfer requests a fill");

    // A failed claim closes the command and carries nothing else.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status) |-> (o_last && !o_fill_valid && !o_writeback_valid))
        else $error("no-slot transfer carries extra fields");

    // A flush writeback transfer is never the last one of its command.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && r_state == lpb_pkg::ST_FWALK && !w_wdone) |-> !w_odata[0])
        else $error("flush writeback marked as last");

endmodule
